// ===== hdl/line_sensor_pid_steering_unit_macros.svh =====
// ----------------------------------------------------------------------------
// line sensor pid steering unit - assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PID_STEERING_UNIT_MACROS_SVH
`define LINE_SENSOR_PID_STEERING_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LSPID_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lspid: same-cycle check failed");

// next-cycle implication
`define LSPID_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lspid: next-cycle check failed");

`else

`define LSPID_ASSERT_IMPL(label, clk, rst, pre, post)
`define LSPID_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== hdl/lspid_pkg.sv =====
// ----------------------------------------------------------------------------
// lspid_pkg
// shared types, constants and the sensor pattern decoder
// ----------------------------------------------------------------------------
package lspid_pkg;

   localparam int INTEGRAL_LIMIT_DEFAULT = 32767;
   localparam int QUEUE_DEPTH_DEFAULT    = 2;

   localparam int SENSOR_W = 7;
   localparam int ERR_W    = 4;
   localparam int DELTA_W  = 5;
   localparam int GAIN_W   = 16;
   localparam int DRIVE_W  = 32;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 2'd2;

   typedef logic [SENSOR_W-1:0]       sensor_type;
   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;

   typedef struct packed {
      logic    found;
      err_type err;
   } decode_type;

   typedef struct packed {
      gain_type p;
      gain_type i;
      gain_type d;
   } gains_type;

   function automatic decode_type decode_sensor(input sensor_type bits);
      decode_type r;
      r.found = 1'b1;
      case (bits)
         7'h40: r.err = -4'sd6;
         7'h60: r.err = -4'sd5;
         7'h20: r.err = -4'sd4;
         7'h30: r.err = -4'sd3;
         7'h10: r.err = -4'sd2;
         7'h18: r.err = -4'sd1;
         7'h08: r.err = 4'sd0;
         7'h0C: r.err = 4'sd1;
         7'h04: r.err = 4'sd2;
         7'h06: r.err = 4'sd3;
         7'h02: r.err = 4'sd4;
         7'h03: r.err = 4'sd5;
         7'h01: r.err = 4'sd6;
         default: begin
            r.found = 1'b0;
            r.err   = 4'sd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/lspid_front.sv =====
// ----------------------------------------------------------------------------
// lspid_front
// decodes sensor samples, updates the clamped integral and previous error
// ----------------------------------------------------------------------------
`include "line_sensor_pid_steering_unit_macros.svh"

module lspid_front #(
   parameter int INTEGRAL_LIMIT = lspid_pkg::INTEGRAL_LIMIT_DEFAULT,
   parameter int SUM_W          = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lspid_pkg::sensor_type   sensor_bits,
   input  logic                    q_full,
   output logic                    q_push,
   output lspid_pkg::err_type      err,
   output logic                    found,
   output logic signed [SUM_W-1:0] sum_value,
   output lspid_pkg::delta_type    delta
);
   import lspid_pkg::*;

   localparam logic signed [SUM_W:0] LIM_POS = (SUM_W+1)'(INTEGRAL_LIMIT);
   localparam logic signed [SUM_W:0] LIM_NEG = -LIM_POS;

   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   err_type                 previous_error_ff, previous_error_in;
   decode_type              dec;
   logic signed [SUM_W:0]   sum_raw;
   logic                    accept;

   assign dec        = decode_sensor(sensor_bits);
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign q_push     = accept;

   assign sum_raw = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(dec.err);

   always_comb begin
      if (sum_raw > LIM_POS) begin
         sum_value = SUM_W'(LIM_POS);
      end else if (sum_raw < LIM_NEG) begin
         sum_value = SUM_W'(LIM_NEG);
      end else begin
         sum_value = SUM_W'(sum_raw);
      end
   end

   assign err   = dec.err;
   assign found = dec.found;
   assign delta = DELTA_W'(dec.err) - DELTA_W'(previous_error_ff);

   always_comb begin
      error_sum_in      = error_sum_ff;
      previous_error_in = previous_error_ff;
      if (accept) begin
         error_sum_in      = sum_value;
         previous_error_in = dec.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= previous_error_in;
      end
   end

   `LSPID_ASSERT_IMPL(a_sum_in_range, clock, reset, 1'b1,
      ((SUM_W+1)'(error_sum_ff) <= LIM_POS) && ((SUM_W+1)'(error_sum_ff) >= LIM_NEG))
   `LSPID_ASSERT_IMPL(a_miss_zero_err, clock, reset, !dec.found, dec.err == 4'sd0)
   `LSPID_ASSERT_NEXT(a_prev_tracks, clock, reset, accept,
      previous_error_ff == $past(dec.err))

endmodule

// ===== hdl/lspid_queue.sv =====
// ----------------------------------------------------------------------------
// lspid_queue
// short register fifo between the front and back parts
// ----------------------------------------------------------------------------
`include "line_sensor_pid_steering_unit_macros.svh"

module lspid_queue #(
   parameter int WIDTH = 27,
   parameter int DEPTH = lspid_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   import lspid_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LSPID_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `LSPID_ASSERT_IMPL(a_no_underflow, clock, reset, pop, valid)
   `LSPID_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)

endmodule

// ===== hdl/lspid_back.sv =====
// ----------------------------------------------------------------------------
// lspid_back
// multiplies by the gains, sums, saturates and holds the response register
// ----------------------------------------------------------------------------
module lspid_back #(
   parameter int SUM_W = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lspid_pkg::gains_type    gains,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  lspid_pkg::err_type      err,
   input  logic                    found,
   input  logic signed [SUM_W-1:0] sum_value,
   input  lspid_pkg::delta_type    delta,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output lspid_pkg::drive_type    drive_value,
   output lspid_pkg::err_type      error_half_units,
   output logic                    line_found
);
   import lspid_pkg::*;

   localparam int PP_W  = GAIN_W + ERR_W;
   localparam int PI_W  = GAIN_W + SUM_W;
   localparam int PD_W  = GAIN_W + DELTA_W;
   localparam int ACC_W = (PI_W + 2 > DRIVE_W + 1) ? PI_W + 2 : DRIVE_W + 1;
   localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] DRV_MIN = ACC_W'(-64'sd2147483648);

   logic                    advance;
   logic signed [PP_W-1:0]  kp_x, e_x;
   logic signed [PI_W-1:0]  ki_x, s_x;
   logic signed [PD_W-1:0]  kd_x, d_x;

   logic                    v1_ff, v1_in;
   logic signed [PP_W-1:0]  pp_ff, pp_in;
   logic signed [PI_W-1:0]  pi_ff, pi_in;
   logic signed [PD_W-1:0]  pd_ff, pd_in;
   err_type                 err1_ff;
   logic                    found1_ff;

   logic signed [ACC_W-1:0] acc;
   logic                    out_v_ff, out_v_in;
   drive_type               drive_ff, drive_in;
   err_type                 err2_ff;
   logic                    found2_ff;

   assign advance = !out_v_ff || rsp_tready;
   assign q_pop   = advance && q_valid;

   // stage 1: products
   assign kp_x  = PP_W'(gains.p);
   assign e_x   = PP_W'(err);
   assign ki_x  = PI_W'(gains.i);
   assign s_x   = PI_W'(sum_value);
   assign kd_x  = PD_W'(gains.d);
   assign d_x   = PD_W'(delta);
   assign pp_in = kp_x * e_x;
   assign pi_in = ki_x * s_x;
   assign pd_in = kd_x * d_x;
   assign v1_in = advance ? q_valid : v1_ff;

   // stage 2: sum and saturate
   assign acc = ACC_W'(pp_ff) + ACC_W'(pi_ff) + ACC_W'(pd_ff);

   always_comb begin
      if (acc > DRV_MAX) begin
         drive_in = DRIVE_W'(DRV_MAX);
      end else if (acc < DRV_MIN) begin
         drive_in = DRIVE_W'(DRV_MIN);
      end else begin
         drive_in = DRIVE_W'(acc);
      end
   end

   assign out_v_in = advance ? v1_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ff     <= pp_in;
         pi_ff     <= pi_in;
         pd_ff     <= pd_in;
         err1_ff   <= err;
         found1_ff <= found;
         drive_ff  <= drive_in;
         err2_ff   <= err1_ff;
         found2_ff <= found1_ff;
      end
   end

   assign rsp_tvalid       = out_v_ff;
   assign drive_value      = drive_ff;
   assign error_half_units = err2_ff;
   assign line_found       = found2_ff;

endmodule

// ===== hdl/line_sensor_pid_steering_unit.sv =====
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_unit
// seven-sensor line follower with a pid steering output
//
//   port group  dir  contents
//   req_*       in   tdata: sensor_bits[6:0]
//   rsp_*       out  tdata: drive_value[31:0], error_half_units[35:32];
//                    tuser: line_found[0]
//   csr_*       in   index 0 gain_p, 1 gain_i, 2 gain_d (signed q8.8)
//
// one request per cycle sustained while rsp_tready stays high; the front keeps the
// integral loop in a single cycle, the back is two stages (multiply, sum and saturate)
// an accepted request is registered in the queue, then in the product and response registers
// synchronous reset clears gains, integral, previous error and all valids
// the queue decouples the sides: the front stalls only when it is full
// ----------------------------------------------------------------------------
module line_sensor_pid_steering_unit #(
   parameter int INTEGRAL_LIMIT = lspid_pkg::INTEGRAL_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH    = lspid_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // sensor_bits
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,   // drive_value, error_half_units
   output logic [0:0]                         rsp_tuser,   // line_found
   input  logic                               csr_we,
   input  logic [lspid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lspid_pkg::GAIN_W-1:0]       csr_wdata
);
   import lspid_pkg::*;

   localparam int SUM_RAW_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
   localparam int SUM_W     = (SUM_RAW_W > ERR_W) ? SUM_RAW_W : ERR_W;
   localparam int Q_W       = DELTA_W + SUM_W + 1 + ERR_W;

   gains_type               gains_ff, gains_in;

   logic                    q_full, q_push, q_pop, q_valid;
   logic [Q_W-1:0]          q_wdata, q_rdata;

   err_type                 f_err, b_err;
   logic                    f_found, b_found;
   logic signed [SUM_W-1:0] f_sum, b_sum;
   delta_type               f_delta, b_delta;

   drive_type               drive_value;
   err_type                 error_half_units;
   logic                    line_found;

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P: gains_in.p = gain_type'(csr_wdata);
            CSR_GAIN_I: gains_in.i = gain_type'(csr_wdata);
            CSR_GAIN_D: gains_in.d = gain_type'(csr_wdata);
            default:    gains_in   = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   lspid_front #(
      .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
      .SUM_W          (SUM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .sensor_bits (req_tdata[SENSOR_W-1:0]),
      .q_full      (q_full),
      .q_push      (q_push),
      .err         (f_err),
      .found       (f_found),
      .sum_value   (f_sum),
      .delta       (f_delta)
   );

   assign q_wdata = {f_delta, f_sum, f_found, f_err};

   lspid_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   assign {b_delta, b_sum, b_found, b_err} = q_rdata;

   lspid_back #(
      .SUM_W (SUM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .gains            (gains_ff),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .err              (b_err),
      .found            (b_found),
      .sum_value        (b_sum),
      .delta            (b_delta),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .drive_value      (drive_value),
      .error_half_units (error_half_units),
      .line_found       (line_found)
   );

   assign rsp_tdata = {4'b0000, error_half_units, drive_value};
   assign rsp_tuser = line_found;

endmodule

// ===== tb/steering_monitor.sv =====
// ----------------------------------------------------------------------------
// steering_monitor
// watches the request, response and register ports of the steering unit,
// predicts drive, error and found flag for every accepted request and
// compares each accepted response field by field with the oldest prediction
// ----------------------------------------------------------------------------
module steering_monitor #(
   parameter int INTEGRAL_LIMIT = lspid_pkg::INTEGRAL_LIMIT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // sensor_bits
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [39:0]                    rsp_tdata,   // drive_value, error_half_units
   input  logic [0:0]                     rsp_tuser,   // line_found
   input  logic                           csr_we,
   input  logic [lspid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lspid_pkg::GAIN_W-1:0]    csr_wdata,
   output int                             outstanding,
   output int                             failures
);
   import lspid_pkg::*;

   localparam longint DRIVE_MAX = 64'sd2147483647;
   localparam longint DRIVE_MIN = -64'sd2147483648;

   typedef struct packed {
      drive_type drive;
      err_type   err;
      logic      found;
   } steer_type;

   gain_type  gain_p, gain_i, gain_d;
   longint    integral;
   int        prev_err;
   steer_type pending_steer_q[$];

   // line position p from far left (0) to far right (12), center at 6
   function automatic logic [6:0] position_pattern(input int p);
      if (p % 2 == 0) begin
         return 7'(1 << (6 - p / 2));
      end
      return 7'(3 << (5 - p / 2));
   endfunction

   function automatic steer_type steer_from_sensors(input sensor_type bits);
      steer_type r;
      int        e;
      longint    acc;
      e       = 0;
      r.found = 1'b0;
      for (int p = 0; p < 13; p++) begin
         if (bits == position_pattern(p)) begin
            e       = p - 6;
            r.found = 1'b1;
         end
      end
      integral = integral + e;
      if (integral > INTEGRAL_LIMIT) begin
         integral = INTEGRAL_LIMIT;
      end else if (integral < -INTEGRAL_LIMIT) begin
         integral = -INTEGRAL_LIMIT;
      end
      acc = longint'(gain_p) * e + longint'(gain_i) * integral
          + longint'(gain_d) * (e - prev_err);
      if (acc > DRIVE_MAX) begin
         acc = DRIVE_MAX;
      end else if (acc < DRIVE_MIN) begin
         acc = DRIVE_MIN;
      end
      r.drive  = drive_type'(acc);
      r.err    = err_type'(e);
      prev_err = e;
      return r;
   endfunction

   always @(posedge clock) begin
      steer_type got;
      steer_type want;
      if (reset) begin
         gain_p   = '0;
         gain_i   = '0;
         gain_d   = '0;
         integral = 0;
         prev_err = 0;
         failures = 0;
         pending_steer_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P: gain_p = csr_wdata;
               CSR_GAIN_I: gain_i = csr_wdata;
               CSR_GAIN_D: gain_d = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive = rsp_tdata[31:0];
            got.err   = rsp_tdata[35:32];
            got.found = rsp_tuser[0];
            if (pending_steer_q.size() == 0) begin
               $error("unexpected response: drive_value %0d", $signed(got.drive));
               failures++;
            end else begin
               want = pending_steer_q.pop_front();
               if (got.drive !== want.drive) begin
                  $error("drive_value mismatch: expected %0d, actual %0d",
                         $signed(want.drive), $signed(got.drive));
                  failures++;
               end
               if (got.err !== want.err) begin
                  $error("error_half_units mismatch: expected %0d, actual %0d",
                         $signed(want.err), $signed(got.err));
                  failures++;
               end
               if (got.found !== want.found) begin
                  $error("line_found mismatch: expected %0b, actual %0b",
                         want.found, got.found);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_steer_q.push_back(steer_from_sensors(req_tdata[6:0]));
         end
      end
      outstanding = pending_steer_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the line sensor pid steering unit: directed sensor patterns,
// wandering-line and noise sequences under several gain settings, one-sided
// runs that push the integral far out and back, and back pressure; the
// monitor does all the checking
// ----------------------------------------------------------------------------
module tb;
   import lspid_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 250;
   localparam int PHASE_ITEMS  = 140;
   localparam int PHASE_COUNT  = 11;
   localparam int DRIFT_ITEMS  = 75;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;    // sensor_bits
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [39:0]          rsp_tdata;    // drive_value, error_half_units
   logic [0:0]           rsp_tuser;    // line_found
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;

   int outstanding;
   int failures;
   int cycles;
   int line_pos;
   bit tx_quiet;
   bit rx_quiet;
   bit rx_hold;

   line_sensor_pid_steering_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   steering_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int pick_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   // line position p from far left (0) to far right (12)
   function automatic logic [6:0] line_pattern(input int p);
      if (p % 2 == 0) begin
         return 7'(1 << (6 - p / 2));
      end
      return 7'(3 << (5 - p / 2));
   endfunction

   task automatic send_sample(input logic [6:0] bits);
      int n;
      n = pick_gap(tx_quiet);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, bits};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_walk();
      line_pos = line_pos + $urandom_range(0, 2) - 1;
      if (line_pos < 0) line_pos = 0;
      if (line_pos > 12) line_pos = 12;
      send_sample(line_pattern(line_pos));
   endtask

   task automatic send_mixed(input int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 7);
         if (r < 5) begin
            send_walk();
         end else if (r == 5) begin
            line_pos = $urandom_range(0, 12);
            send_sample(line_pattern(line_pos));
         end else begin
            send_sample(7'($urandom_range(0, 127)));
         end
      end
   endtask

   // wait for every response, then let the pipeline drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic set_gains(input gain_type kp, input gain_type ki, input gain_type kd);
      settle();
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CSR_UNUSED, 16'($urandom));
      end
      csr_we <= 1'b0;
   endtask

   // response side
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rx_hold = 1'b0;
         end
         n = pick_gap(rx_quiet);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // request side
   initial begin
      gain_type kp, ki, kd;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      tx_quiet   = 1'b0;
      rx_quiet   = 1'b0;
      rx_hold    = 1'b0;
      line_pos   = 6;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every recognized position, jumps across the array, unrecognized patterns
      set_gains(16'sd256, 16'sd32, -16'sd512);
      for (int p = 0; p < 13; p++) send_sample(line_pattern(p));
      send_sample(7'h40);
      send_sample(7'h01);
      send_sample(7'h00);
      send_sample(7'h7F);
      send_sample(7'h41);
      send_sample(7'h14);
      send_sample(7'h5A);
      send_sample(7'h70);
      send_sample(7'h2A);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin kp = 16'sh7FFF; ki = 16'sh7FFF; kd = 16'sh7FFF; end
            1: begin kp = 16'sh8000; ki = 16'sh8000; kd = 16'sh8000; end
            2: begin kp = 16'sh7FFF; ki = 16'sh8000; kd = 16'sh7FFF; end
            3: begin kp = 16'sh8000; ki = 16'sh7FFF; kd = 16'sh8000; end
            4: begin kp = '0; ki = '0; kd = '0; end
            5: begin kp = 16'sd1; ki = -16'sd1; kd = 16'sd1; end
            default: begin
               kp = 16'($urandom);
               ki = 16'($urandom);
               kd = 16'($urandom);
            end
         endcase
         set_gains(kp, ki, kd);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         send_mixed(PHASE_ITEMS / 2);
         if (ph == 2) begin
            // response side stalls while requests keep coming
            rx_hold  = 1'b1;
            tx_quiet = 1'b1;
            send_mixed(40);
            tx_quiet = 1'b0;
         end
         if (ph == 6) begin
            settle();
         end
         send_mixed(PHASE_ITEMS / 2);
      end

      // push the integral far to the right, then back to the left
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      set_gains(16'($urandom), 16'sh7FFF, 16'($urandom));
      for (int k = 0; k < DRIFT_ITEMS; k++) begin
         send_sample(($urandom_range(0, 7) == 0) ? 7'h03 : 7'h01);
      end
      set_gains(16'($urandom), 16'sh8000, 16'($urandom));
      for (int k = 0; k < DRIFT_ITEMS; k++) begin
         send_sample(($urandom_range(0, 7) == 0) ? 7'h60 : 7'h40);
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      set_gains(16'($urandom), 16'($urandom), 16'($urandom));
      send_mixed(100);

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
